### rtl/core/bblur_pkg.sv
`timescale 1ns / 1ps

package bblur_pkg;

   // Default bounds handed to the top level parameters.
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // Fixed widths of the configuration registers and result fields.
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int PIXEL_W        = 32;
   localparam int OUT_COL_W      = 11;
   localparam int OUT_ROW_W      = 12;

   localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // A column sum holds three bytes, a window sum nine.
   localparam int COLSUM_W = 10;
   localparam int SUM_W    = 12;

   // Division by nine as a multiplication by the rounded-up reciprocal.
   // Exact for every sum below 32768, far beyond the largest window sum.
   localparam int            DIV9_MUL_W = 13;
   localparam logic [12:0]   DIV9_MUL   = 13'd7282;
   localparam int            DIV9_SHIFT = 16;
   localparam int            PROD_W     = SUM_W + DIV9_MUL_W;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified window on its way to the back: the three column sums of
   // each colour channel (column 0 leftmost, channel 0 blue), the centre
   // alpha and the position of the centre pixel.
   typedef struct packed {
      logic [7:0]                        alpha;
      logic [2:0][2:0][COLSUM_W-1:0]     colsum;
      logic [OUT_COL_W-1:0]              col;
      logic [OUT_ROW_W-1:0]              row;
      logic                              done;
   } bblur_item_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } bblur_qstat_type;

endpackage

### rtl/core/bblur_ram.sv
`timescale 1ns / 1ps

module bblur_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/bblur_queue.sv
`timescale 1ns / 1ps

module bblur_queue
   import bblur_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  bblur_item_type  push_item,
   input  logic            pop,
   output bblur_item_type  pop_item,
   output bblur_qstat_type qstat
);

   bblur_item_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item    = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

   // The front reserves a slot before it accepts a pixel, so a push never
   // finds the queue full.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
      else $error("queue pushed while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with an empty count");

endmodule

### rtl/core/bblur_front.sv
`timescale 1ns / 1ps

module bblur_front
   import bblur_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [PIXEL_W-1:0]        req_pixel_in,
   input  logic                      req_frame_start,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [FRAME_WIDTH_W-1:0]  frame_width,
   input  logic [FRAME_HEIGHT_W-1:0] frame_height,
   input  bblur_qstat_type           qstat,
   output logic                      push,
   output bblur_item_type            item
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic          accept;
   logic [CW-1:0] wlast;
   logic [RW-1:0] hlast;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_in;

   logic                 s1_valid_ff;
   logic [PIXEL_W-1:0]   s1_pix_ff;
   logic [CW-1:0]        s1_idx_ff;
   logic                 s1_produce_ff;
   logic [OUT_COL_W-1:0] s1_col_ff;
   logic [OUT_ROW_W-1:0] s1_row_ff;
   logic                 s1_done_ff;
   logic                 s1_fwd_ff;
   logic [PIXEL_W-1:0]   fwd_data_ff;

   logic [PIXEL_W-1:0] prev_rdata;
   logic [PIXEL_W-1:0] prev2_rdata;
   logic [PIXEL_W-1:0] top;
   logic [PIXEL_W-1:0] mid;

   logic [2:0][COLSUM_W-1:0] new_colsum;
   logic [2:0][COLSUM_W-1:0] colsum1_ff;
   logic [2:0][COLSUM_W-1:0] colsum2_ff;
   logic [7:0]               alpha_r_ff;

   // A slot is reserved for the pixel still in the read stage.
   assign req_full = (int'(qstat.count) + int'(s1_valid_ff)) >= QUEUE_DEPTH;
   assign accept   = req_push && !req_full;

   // Last column and row index after bounding the registers.
   always_comb begin
      if (frame_width == '0) begin
         wlast = '0;
      end else if (int'(frame_width) > MAX_WIDTH) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(frame_width - 1'b1);
      end
      if (frame_height == '0) begin
         hlast = '0;
      end else if (int'(frame_height) > MAX_HEIGHT) begin
         hlast = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast = RW'(frame_height - 1'b1);
      end
   end

   assign cur_col = req_frame_start ? '0 : col_ff;
   assign cur_row = req_frame_start ? '0 : row_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (cur_col >= wlast) begin
            col_in = '0;
            row_in = (cur_row >= hlast) ? '0 : cur_row + 1'b1;
         end else begin
            col_in = cur_col + 1'b1;
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // Capture the pixel and its classification while the line stores read.
   // When the previous pixel writes the same entry of the older line store
   // in this very cycle, its word is kept aside and used instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= req_pixel_in;
         s1_idx_ff     <= cur_col;
         s1_produce_ff <= (cur_col >= CW'(2)) && (cur_row >= RW'(2));
         s1_col_ff     <= OUT_COL_W'(cur_col - 1'b1);
         s1_row_ff     <= OUT_ROW_W'(cur_row - 1'b1);
         s1_done_ff    <= (cur_col == wlast) && (cur_row == hlast);
         s1_fwd_ff     <= s1_valid_ff && (s1_idx_ff == cur_col);
         fwd_data_ff   <= prev_rdata;
      end
   end

   bblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_prev (
      .clock (clock),
      .we    (accept),
      .waddr (cur_col),
      .wdata (req_pixel_in),
      .re    (accept),
      .raddr (cur_col),
      .rdata (prev_rdata)
   );

   bblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_prev2 (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_idx_ff),
      .wdata (prev_rdata),
      .re    (accept),
      .raddr (cur_col),
      .rdata (prev2_rdata)
   );

   assign mid = prev_rdata;
   assign top = s1_fwd_ff ? fwd_data_ff : prev2_rdata;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         new_colsum[ch] = COLSUM_W'(top[8*ch +: 8]) + COLSUM_W'(mid[8*ch +: 8])
                        + COLSUM_W'(s1_pix_ff[8*ch +: 8]);
      end
   end

   // The window is kept as per-column channel sums; the rightmost column
   // exists only in the item handed to the queue.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         colsum1_ff <= colsum2_ff;
         colsum2_ff <= new_colsum;
         alpha_r_ff <= mid[31:24];
      end
   end

   assign push             = s1_valid_ff && s1_produce_ff;
   assign item.alpha       = alpha_r_ff;
   assign item.colsum[0]   = colsum1_ff;
   assign item.colsum[1]   = colsum2_ff;
   assign item.colsum[2]   = new_colsum;
   assign item.col         = s1_col_ff;
   assign item.row         = s1_row_ff;
   assign item.done        = s1_done_ff;

endmodule

### rtl/core/bblur_back.sv
`timescale 1ns / 1ps

module bblur_back
   import bblur_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bblur_qstat_type      qstat,
   input  bblur_item_type       pop_item,
   output logic                 q_pop,
   output logic [PIXEL_W-1:0]   rsp_pixel_out,
   output logic [OUT_COL_W-1:0] rsp_out_col,
   output logic [OUT_ROW_W-1:0] rsp_out_row,
   output logic                 rsp_frame_done,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);

   logic                       b1_valid_ff;
   logic [2:0][SUM_W-1:0]      b1_sum_ff;
   logic [7:0]                 b1_alpha_ff;
   logic [OUT_COL_W-1:0]       b1_col_ff;
   logic [OUT_ROW_W-1:0]       b1_row_ff;
   logic                       b1_done_ff;
   logic [2:0][SUM_W-1:0]      sum;

   logic                       b2_valid_ff;
   logic [PIXEL_W-1:0]         b2_pixel_ff;
   logic [OUT_COL_W-1:0]       b2_col_ff;
   logic [OUT_ROW_W-1:0]       b2_row_ff;
   logic                       b2_done_ff;
   logic [2:0][PROD_W-1:0]     prod;
   logic [2:0][7:0]            quot;

   logic b1_ready;
   logic b2_ready;

   assign b2_ready = !b2_valid_ff || rsp_pop;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign q_pop    = !qstat.empty && b1_ready;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = SUM_W'(pop_item.colsum[0][ch]) + SUM_W'(pop_item.colsum[1][ch])
                 + SUM_W'(pop_item.colsum[2][ch]);
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = PROD_W'(b1_sum_ff[ch]) * PROD_W'(DIV9_MUL);
         quot[ch] = prod[ch][DIV9_SHIFT +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_valid_ff <= q_pop;
         end
         if (b2_ready) begin
            b2_valid_ff <= b1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_sum_ff   <= sum;
         b1_alpha_ff <= pop_item.alpha;
         b1_col_ff   <= pop_item.col;
         b1_row_ff   <= pop_item.row;
         b1_done_ff  <= pop_item.done;
      end
      if (b2_ready && b1_valid_ff) begin
         b2_pixel_ff <= {b1_alpha_ff, quot[2], quot[1], quot[0]};
         b2_col_ff   <= b1_col_ff;
         b2_row_ff   <= b1_row_ff;
         b2_done_ff  <= b1_done_ff;
      end
   end

   assign rsp_pixel_out  = b2_pixel_ff;
   assign rsp_out_col    = b2_col_ff;
   assign rsp_out_row    = b2_row_ff;
   assign rsp_frame_done = b2_done_ff;
   assign rsp_empty      = !b2_valid_ff;

endmodule

### rtl/core/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps

// 3x3 box filter over a raster stream of ARGB pixels.
// Requests enter through req_pixel_in and req_frame_start, and are taken at a
// clock edge where req_push is high and req_full is low. Each interior pixel
// of the frame yields one result on the rsp_ ports; border pixels yield none.
// A result waits on the rsp_ ports while rsp_empty is low and leaves at an
// edge where rsp_pop is high. The red, green and blue bytes are the truncated
// mean of the nine neighbours; alpha is that of the centre pixel.
// One request is taken every clock while req_full is low. Each request reads
// both line stores once and writes each once, using one read and one write
// port per store per cycle, and that single pass per pixel sets the rate. A
// result passes the read stage, the queue and two output stages to reach the
// rsp_ ports. If the receiver stalls, the four-entry queue and the output
// stages fill up and req_full rises; nothing is lost. The user must write the
// frame registers through the csr_ port only while no request is in flight;
// the block does not enforce this. Reset clears the position counters and all
// pipeline and queue state, and sets the frame to 640 by 480. The line stores
// are not cleared; every entry that a result uses was written in that frame.

module box_blur_3x3_rgb
   import bblur_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic [PIXEL_W-1:0]    req_pixel_in,
   input  logic                  req_frame_start,
   input  logic                  req_push,
   output logic                  req_full,

   output logic [PIXEL_W-1:0]    rsp_pixel_out,
   output logic [OUT_COL_W-1:0]  rsp_out_col,
   output logic [OUT_ROW_W-1:0]  rsp_out_row,
   output logic                  rsp_frame_done,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [FRAME_WIDTH_W-1:0]  frame_width_in;
   logic [FRAME_HEIGHT_W-1:0] frame_height_in;

   bblur_qstat_type qstat;
   bblur_item_type  push_item;
   bblur_item_type  pop_item;
   logic            q_push;
   logic            q_pop;

   // Writes to indexes beyond the two frame registers are ignored.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[FRAME_WIDTH_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[FRAME_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // The front tracks the position, keeps the line stores and the window,
   // and hands every interior window to the queue as column sums.
   bblur_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .req_push        (req_push),
      .req_full        (req_full),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .qstat           (qstat),
      .push            (q_push),
      .item            (push_item)
   );

   bblur_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // The back totals the columns, divides by nine and holds the result
   // until the receiver takes it.
   bblur_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .pop_item       (pop_item),
      .q_pop          (q_pop),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule
